// ===== rtl/ttf_pkg.sv =====
`timescale 1ns / 1ps

package ttf_pkg;

    // Component width of every packed vector field.
    localparam int CW = 16;
    // Fraction bits of a unit vector component (Q1.14).
    localparam int FRAC = 14;
    // Width of the UV-derived reference bitangent after its sign correction.
    localparam int BW = 36;
    // Width of a tangent magnitude after normalization into [2^29, 2^30).
    localparam int MW = 30;
    // Width of the sum of the three squared magnitudes.
    localparam int SW = 2 * MW + 2;
    // Width of the integer vector length.
    localparam int LW = MW + 1;
    // Width of one normalized component quotient (at most 2^14).
    localparam int QW = FRAC + 1;
    // Threshold register width and reset value.
    localparam int THR_W = 31;
    localparam logic [THR_W-1:0] THR_RESET = 31'd1074;
    // Unit value in Q1.14.
    localparam logic signed [CW-1:0] ONE_Q14 = 16'sd16384;

    // One triangle.
    typedef struct packed {
        logic [3*CW-1:0] pos_a;
        logic [3*CW-1:0] pos_b;
        logic [3*CW-1:0] pos_c;
        logic [2*CW-1:0] tex_a;
        logic [2*CW-1:0] tex_b;
        logic [2*CW-1:0] tex_c;
        logic [3*CW-1:0] surface_normal;
    } ttf_in_t;

    // One tangent frame.
    typedef struct packed {
        logic [3*CW-1:0] tangent_out;
        logic [3*CW-1:0] bitangent_out;
        logic            degenerate;
    } ttf_out_t;

    // Side information that travels with a triangle through the length
    // and divide stages.
    typedef struct packed {
        logic [2:0]          neg;
        logic                zero;
        logic                degen;
        logic [3*CW-1:0]     normal;
        logic [2:0][BW-1:0]  bref;
    } ttf_ctx_t;

    // Three normalized tangent magnitudes.
    typedef logic [2:0][MW-1:0] ttf_mag3_t;

endpackage

// ===== rtl/ttf_front.sv =====
`timescale 1ns / 1ps

module ttf_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       req_valid,
    input  ttf_pkg::ttf_in_t           req,
    input  logic [ttf_pkg::THR_W-1:0]  threshold,
    output logic                       res_valid,
    output logic [ttf_pkg::SW-1:0]     res_sum,
    output ttf_pkg::ttf_mag3_t         res_mag,
    output ttf_pkg::ttf_ctx_t          res_ctx
);
    import ttf_pkg::*;

    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int DW = PW + 1;
    localparam int DET_SH = 6;
    localparam int PSW = $clog2(BW);
    localparam int NST = 8;

    function automatic logic signed [EW-1:0] sx(input logic [CW-1:0] w);
        return $signed({w[CW-1], w});
    endfunction

    logic [NST-1:0] vld_reg;

    // Stage 1: edges and UV deltas.
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];
    logic signed [EW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [EW-1:0] du1_next, dv1_next, du2_next, dv2_next;
    logic [3*CW-1:0]      n1_reg;

    // Stage 2: products.
    logic signed [PW-1:0] pt1_reg [3];
    logic signed [PW-1:0] pt2_reg [3];
    logic signed [PW-1:0] pb1_reg [3];
    logic signed [PW-1:0] pb2_reg [3];
    logic signed [PW-1:0] pt1_next [3];
    logic signed [PW-1:0] pt2_next [3];
    logic signed [PW-1:0] pb1_next [3];
    logic signed [PW-1:0] pb2_next [3];
    logic signed [PW-1:0] pd1_reg, pd2_reg, pd1_next, pd2_next;
    logic [3*CW-1:0]      n2_reg;

    // Stage 3: determinant, tangent and reference.
    logic signed [DW-1:0] t3_reg [3];
    logic signed [DW-1:0] b3_reg [3];
    logic signed [DW-1:0] t3_next [3];
    logic signed [DW-1:0] b3_next [3];
    logic signed [DW-1:0] det3_reg, det3_next;
    logic [3*CW-1:0]      n3_reg;

    // Stage 4: sign fix, threshold and magnitudes.
    logic [2:0][BW-1:0] m4_reg, m4_next;
    logic [2:0][BW-1:0] bref4_reg, bref4_next;
    logic [2:0]         sgn4_reg, sgn4_next;
    logic               degen4_reg, degen4_next;
    logic [3*CW-1:0]    n4_reg;

    // Stage 5: leading one of the largest magnitude.
    logic [2:0][BW-1:0] m5_reg;
    logic [PSW-1:0]     pos5_reg, pos5_next;
    ttf_ctx_t           ctx5_reg, ctx5_next;

    // Stage 6: normalized magnitudes.
    ttf_mag3_t ms6_reg, ms6_next;
    ttf_ctx_t  ctx6_reg;

    // Stage 7: squares.
    logic [2:0][2*MW-1:0] sq7_reg, sq7_next;
    ttf_mag3_t            ms7_reg;
    ttf_ctx_t             ctx7_reg;

    // Stage 8: sum of squares.
    logic [SW-1:0] sum8_reg, sum8_next;
    ttf_mag3_t     ms8_reg;
    ttf_ctx_t      ctx8_reg;

    // Edge vectors and UV deltas.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1_next[i] = sx(req.pos_b[CW*i +: CW]) - sx(req.pos_a[CW*i +: CW]);
            e2_next[i] = sx(req.pos_c[CW*i +: CW]) - sx(req.pos_a[CW*i +: CW]);
        end
        du1_next = sx(req.tex_b[CW-1:0]) - sx(req.tex_a[CW-1:0]);
        dv1_next = sx(req.tex_b[2*CW-1:CW]) - sx(req.tex_a[2*CW-1:CW]);
        du2_next = sx(req.tex_c[CW-1:0]) - sx(req.tex_a[CW-1:0]);
        dv2_next = sx(req.tex_c[2*CW-1:CW]) - sx(req.tex_a[2*CW-1:CW]);
    end

    // Cross products of edges with UV deltas.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt1_next[i] = e1_reg[i] * dv2_reg;
            pt2_next[i] = e2_reg[i] * dv1_reg;
            pb1_next[i] = e2_reg[i] * du1_reg;
            pb2_next[i] = e1_reg[i] * du2_reg;
        end
        pd1_next = du1_reg * dv2_reg;
        pd2_next = dv1_reg * du2_reg;
    end

    // Differences.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t3_next[i] = DW'(pt1_reg[i]) - DW'(pt2_reg[i]);
            b3_next[i] = DW'(pb1_reg[i]) - DW'(pb2_reg[i]);
        end
        det3_next = DW'(pd1_reg) - DW'(pd2_reg);
    end

    // Orientation by the determinant sign, and the degenerate test.
    always_comb
    begin
        logic              det_neg;
        logic [DW-1:0]     det_mag;
        logic signed [BW-1:0] tf;
        logic signed [BW-1:0] bf;
        det_neg = det3_reg[DW-1];
        det_mag = det_neg ? -det3_reg : det3_reg;
        degen4_next = {det_mag, {DET_SH{1'b0}}} < (DW + DET_SH)'(threshold);
        for (int i = 0; i < 3; i++)
        begin
            tf = det_neg ? -BW'(t3_reg[i]) : BW'(t3_reg[i]);
            bf = det_neg ? -BW'(b3_reg[i]) : BW'(b3_reg[i]);
            sgn4_next[i] = tf[BW-1];
            m4_next[i] = tf[BW-1] ? -tf : tf;
            if (degen4_next)
            begin
                bref4_next[i] = (i == 2) ? BW'(1) : '0;
            end
            else
            begin
                bref4_next[i] = bf;
            end
        end
    end

    // Position of the leading one over all three magnitudes.
    always_comb
    begin
        logic [BW-1:0] orv;
        orv = m4_reg[0] | m4_reg[1] | m4_reg[2];
        pos5_next = '0;
        for (int i = 0; i < BW; i++)
        begin
            if (orv[i])
            begin
                pos5_next = PSW'(i);
            end
        end
        ctx5_next.neg = sgn4_reg;
        ctx5_next.zero = (orv == '0);
        ctx5_next.degen = degen4_reg;
        ctx5_next.normal = n4_reg;
        ctx5_next.bref = bref4_reg;
    end

    // Shift so that the largest magnitude lies in [2^(MW-1), 2^MW).
    always_comb
    begin
        logic [BW-1:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            if (pos5_reg > PSW'(MW - 1))
            begin
                sh = m5_reg[i] >> (pos5_reg - PSW'(MW - 1));
            end
            else
            begin
                sh = m5_reg[i] << (PSW'(MW - 1) - pos5_reg);
            end
            ms6_next[i] = sh[MW-1:0];
        end
    end

    // Squares and their sum.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq7_next[i] = ms6_reg[i] * ms6_reg[i];
        end
        sum8_next = SW'(sq7_reg[0]) + SW'(sq7_reg[1]) + SW'(sq7_reg[2]);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], req_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            du1_reg <= du1_next;
            dv1_reg <= dv1_next;
            du2_reg <= du2_next;
            dv2_reg <= dv2_next;
            n1_reg <= req.surface_normal;

            pt1_reg <= pt1_next;
            pt2_reg <= pt2_next;
            pb1_reg <= pb1_next;
            pb2_reg <= pb2_next;
            pd1_reg <= pd1_next;
            pd2_reg <= pd2_next;
            n2_reg <= n1_reg;

            t3_reg <= t3_next;
            b3_reg <= b3_next;
            det3_reg <= det3_next;
            n3_reg <= n2_reg;

            m4_reg <= m4_next;
            bref4_reg <= bref4_next;
            sgn4_reg <= sgn4_next;
            degen4_reg <= degen4_next;
            n4_reg <= n3_reg;

            m5_reg <= m4_reg;
            pos5_reg <= pos5_next;
            ctx5_reg <= ctx5_next;

            ms6_reg <= ms6_next;
            ctx6_reg <= ctx5_reg;

            sq7_reg <= sq7_next;
            ms7_reg <= ms6_reg;
            ctx7_reg <= ctx6_reg;

            sum8_reg <= sum8_next;
            ms8_reg <= ms7_reg;
            ctx8_reg <= ctx7_reg;
        end
    end

    assign res_valid = vld_reg[NST-1];
    assign res_sum = sum8_reg;
    assign res_mag = ms8_reg;
    assign res_ctx = ctx8_reg;

endmodule

// ===== rtl/ttf_isqrt.sv =====
`timescale 1ns / 1ps

module ttf_isqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    req_valid,
    input  logic [ttf_pkg::SW-1:0]  req_sum,
    input  ttf_pkg::ttf_mag3_t      req_mag,
    input  ttf_pkg::ttf_ctx_t       req_ctx,
    output logic                    res_valid,
    output logic [ttf_pkg::LW-1:0]  res_len,
    output ttf_pkg::ttf_mag3_t      res_mag,
    output ttf_pkg::ttf_ctx_t       res_ctx
);
    import ttf_pkg::*;

    // One result bit per step, two steps per stage.
    localparam int STEPS = SW / 2;
    localparam int NS = (STEPS + 1) / 2;
    localparam int XW = SW + 2;

    logic [NS-1:0]   v_reg;
    logic [XW-1:0]   x_reg [NS];
    logic [XW-1:0]   r_reg [NS];
    logic [XW-1:0]   x_next [NS];
    logic [XW-1:0]   r_next [NS];
    logic [XW-1:0]   x_in [NS];
    logic [XW-1:0]   r_in [NS];
    ttf_mag3_t       m_reg [NS];
    ttf_ctx_t        c_reg [NS];

    // Stage inputs.
    always_comb
    begin
        x_in[0] = XW'(req_sum);
        r_in[0] = '0;
        for (int s = 1; s < NS; s++)
        begin
            x_in[s] = x_reg[s-1];
            r_in[s] = r_reg[s-1];
        end
    end

    // Digit-by-digit square root, two steps per stage.
    always_comb
    begin
        logic [XW-1:0] xs;
        logic [XW-1:0] rs;
        logic [XW-1:0] bitv;
        for (int s = 0; s < NS; s++)
        begin
            xs = x_in[s];
            rs = r_in[s];
            for (int j = 0; j < 2; j++)
            begin
                if (2 * s + j < STEPS)
                begin
                    bitv = XW'(1) << (2 * (STEPS - 1 - 2 * s - j));
                    if (xs >= rs + bitv)
                    begin
                        xs = xs - (rs + bitv);
                        rs = (rs >> 1) + bitv;
                    end
                    else
                    begin
                        rs = rs >> 1;
                    end
                end
            end
            x_next[s] = xs;
            r_next[s] = rs;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], req_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= req_mag;
            c_reg[0] <= req_ctx;
            for (int s = 1; s < NS; s++)
            begin
                m_reg[s] <= m_reg[s-1];
                c_reg[s] <= c_reg[s-1];
            end
            for (int s = 0; s < NS; s++)
            begin
                x_reg[s] <= x_next[s];
                r_reg[s] <= r_next[s];
            end
        end
    end

    assign res_valid = v_reg[NS-1];
    assign res_len = r_reg[NS-1][LW-1:0];
    assign res_mag = m_reg[NS-1];
    assign res_ctx = c_reg[NS-1];

endmodule

// ===== rtl/ttf_div.sv =====
`timescale 1ns / 1ps

module ttf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         req_valid,
    input  logic [ttf_pkg::LW-1:0]       req_len,
    input  ttf_pkg::ttf_mag3_t           req_mag,
    input  ttf_pkg::ttf_ctx_t            req_ctx,
    output logic                         res_valid,
    output logic [2:0][ttf_pkg::QW-1:0]  res_quo,
    output ttf_pkg::ttf_ctx_t            res_ctx
);
    import ttf_pkg::*;

    // Two quotient bits per stage, three lanes sharing one divisor.
    localparam int DS = (QW + 1) / 2;
    localparam int RW = MW + QW + 1;

    logic [DS-1:0]          v_reg;
    logic [2:0][RW-1:0]     rem_reg [DS];
    logic [2:0][RW-1:0]     rem_next [DS];
    logic [2:0][RW-1:0]     rem_in [DS];
    logic [2:0][QW-1:0]     q_reg [DS];
    logic [2:0][QW-1:0]     q_next [DS];
    logic [2:0][QW-1:0]     q_in [DS];
    logic [LW-1:0]          len_reg [DS];
    logic [LW-1:0]          len_in [DS];
    ttf_ctx_t               c_reg [DS];

    // Stage inputs; the first holds the rounded numerator.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_in[0][i] = (RW'(req_mag[i]) << FRAC) + RW'(req_len >> 1);
        end
        q_in[0] = '0;
        len_in[0] = req_len;
        for (int s = 1; s < DS; s++)
        begin
            rem_in[s] = rem_reg[s-1];
            q_in[s] = q_reg[s-1];
            len_in[s] = len_reg[s-1];
        end
    end

    // Restoring division steps.
    always_comb
    begin
        logic [RW-1:0] rs;
        logic [RW-1:0] d;
        logic [QW-1:0] qs;
        for (int s = 0; s < DS; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rs = rem_in[s][i];
                qs = q_in[s][i];
                for (int j = 0; j < 2; j++)
                begin
                    if (QW - 1 - 2 * s - j >= 0)
                    begin
                        d = RW'(len_in[s]) << (QW - 1 - 2 * s - j);
                        if (rs >= d)
                        begin
                            rs = rs - d;
                            qs[QW - 1 - 2 * s - j] = 1'b1;
                        end
                    end
                end
                rem_next[s][i] = rs;
                q_next[s][i] = qs;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DS-2:0], req_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0] <= req_ctx;
            for (int s = 1; s < DS; s++)
            begin
                c_reg[s] <= c_reg[s-1];
            end
            for (int s = 0; s < DS; s++)
            begin
                rem_reg[s] <= rem_next[s];
                q_reg[s] <= q_next[s];
                len_reg[s] <= len_in[s];
            end
        end
    end

    assign res_valid = v_reg[DS-1];
    assign res_quo = q_reg[DS-1];
    assign res_ctx = c_reg[DS-1];

endmodule

// ===== rtl/ttf_back.sv =====
`timescale 1ns / 1ps

module ttf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         req_valid,
    input  logic [2:0][ttf_pkg::QW-1:0]  req_quo,
    input  ttf_pkg::ttf_ctx_t            req_ctx,
    output logic                         res_valid,
    output ttf_pkg::ttf_out_t            res
);
    import ttf_pkg::*;

    localparam int PW = 2 * CW;
    localparam int XW = PW + 1;
    localparam int RQW = XW - FRAC;
    localparam int DPW = CW + BW;
    localparam int DSW = DPW + 2;
    localparam int NST = 6;
    localparam logic [XW-1:0] HALF = XW'(1) << (FRAC - 1);
    localparam logic signed [RQW:0] CMAX = (RQW + 1)'(2 ** (CW - 1) - 1);
    localparam logic signed [RQW:0] CMIN = ~CMAX;

    function automatic logic signed [CW-1:0] sat_c(input logic signed [RQW:0] v);
        logic signed [CW-1:0] r;
        if (v > CMAX)
        begin
            r = CMAX[CW-1:0];
        end
        else if (v < CMIN)
        begin
            r = CMIN[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    logic [NST-1:0] vld_reg;

    // Stage 1: signed unit tangent.
    logic signed [CW-1:0] tu1_reg [3];
    logic signed [CW-1:0] tu1_next [3];
    logic signed [CW-1:0] n1_reg [3];
    logic signed [CW-1:0] n1_next [3];
    logic [2:0][BW-1:0]   bref1_reg;
    logic                 degen1_reg;

    // Stage 2: cross product terms.
    logic signed [PW-1:0] cp2_reg [3];
    logic signed [PW-1:0] cm2_reg [3];
    logic signed [PW-1:0] cp2_next [3];
    logic signed [PW-1:0] cm2_next [3];
    logic signed [CW-1:0] tu2_reg [3];
    logic [2:0][BW-1:0]   bref2_reg;
    logic                 degen2_reg;

    // Stage 3: cross product.
    logic signed [XW-1:0] x3_reg [3];
    logic signed [XW-1:0] x3_next [3];
    logic signed [CW-1:0] tu3_reg [3];
    logic [2:0][BW-1:0]   bref3_reg;
    logic                 degen3_reg;

    // Stage 4: rounded bitangent.
    logic signed [CW-1:0] bt4_reg [3];
    logic signed [CW-1:0] bt4_next [3];
    logic signed [CW-1:0] tu4_reg [3];
    logic [2:0][BW-1:0]   bref4_reg;
    logic                 degen4_reg;

    // Stage 5: terms of the dot product with the reference.
    logic signed [DPW-1:0] pr5_reg [3];
    logic signed [DPW-1:0] pr5_next [3];
    logic signed [CW-1:0]  bt5_reg [3];
    logic signed [CW-1:0]  tu5_reg [3];
    logic                  degen5_reg;

    // Stage 6: output register.
    ttf_out_t out6_reg, out6_next;

    // Tangent sign and special frames.
    always_comb
    begin
        logic signed [CW-1:0] qv;
        for (int i = 0; i < 3; i++)
        begin
            qv = $signed({1'b0, req_quo[i]});
            n1_next[i] = $signed(req_ctx.normal[CW*i +: CW]);
            if (req_ctx.degen)
            begin
                tu1_next[i] = (i == 0) ? ONE_Q14 : '0;
            end
            else if (req_ctx.zero)
            begin
                tu1_next[i] = '0;
            end
            else
            begin
                tu1_next[i] = req_ctx.neg[i] ? -qv : qv;
            end
        end
    end

    // Normal cross tangent.
    always_comb
    begin
        int a;
        int b;
        for (int i = 0; i < 3; i++)
        begin
            a = (i == 2) ? 0 : i + 1;
            b = (i == 0) ? 2 : i - 1;
            cp2_next[i] = n1_reg[a] * tu1_reg[b];
            cm2_next[i] = n1_reg[b] * tu1_reg[a];
            x3_next[i] = XW'(cp2_reg[i]) - XW'(cm2_reg[i]);
        end
    end

    // Round half away from zero to Q1.14 and saturate.
    always_comb
    begin
        logic [XW-1:0]     mag;
        logic [XW-1:0]     rnd;
        logic signed [RQW:0] v;
        for (int i = 0; i < 3; i++)
        begin
            mag = x3_reg[i][XW-1] ? -x3_reg[i] : x3_reg[i];
            rnd = (mag + HALF) >> FRAC;
            v = $signed({1'b0, rnd[RQW-1:0]});
            bt4_next[i] = sat_c(x3_reg[i][XW-1] ? -v : v);
        end
    end

    // Dot product terms.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pr5_next[i] = bt4_reg[i] * $signed(bref4_reg[i]);
        end
    end

    // Flip the bitangent when it opposes the reference.
    always_comb
    begin
        logic signed [DSW-1:0] dot;
        logic signed [CW-1:0]  bf [3];
        dot = DSW'(pr5_reg[0]) + DSW'(pr5_reg[1]) + DSW'(pr5_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            bf[i] = dot[DSW-1] ? sat_c(-(RQW + 1)'(bt5_reg[i])) : bt5_reg[i];
        end
        out6_next.tangent_out = {tu5_reg[2], tu5_reg[1], tu5_reg[0]};
        out6_next.bitangent_out = {bf[2], bf[1], bf[0]};
        out6_next.degenerate = degen5_reg;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], req_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tu1_reg <= tu1_next;
            n1_reg <= n1_next;
            bref1_reg <= req_ctx.bref;
            degen1_reg <= req_ctx.degen;

            cp2_reg <= cp2_next;
            cm2_reg <= cm2_next;
            tu2_reg <= tu1_reg;
            bref2_reg <= bref1_reg;
            degen2_reg <= degen1_reg;

            x3_reg <= x3_next;
            tu3_reg <= tu2_reg;
            bref3_reg <= bref2_reg;
            degen3_reg <= degen2_reg;

            bt4_reg <= bt4_next;
            tu4_reg <= tu3_reg;
            bref4_reg <= bref3_reg;
            degen4_reg <= degen3_reg;

            pr5_reg <= pr5_next;
            bt5_reg <= bt4_reg;
            tu5_reg <= tu4_reg;
            degen5_reg <= degen4_reg;

            out6_reg <= out6_next;
        end
    end

    assign res_valid = vld_reg[NST-1];
    assign res = out6_reg;

endmodule

// ===== rtl/triangle_tangent_frame_unit.sv =====
`timescale 1ns / 1ps

// Triangle tangent frame unit.
// The tri channel (tri_valid, tri_stall, tri_data) takes one triangle per
// request: three positions, three texture coordinates and the normal.
// The frame channel (frame_valid, frame_stall, frame_data) returns one
// tangent frame per triangle, in order: unit tangent, corrected bitangent
// and a flag for the fallback frame used on a small UV determinant.
// The cfg channel writes the determinant threshold whenever cfg_valid is
// high; cfg_ready is always high. Write it only while the unit is empty.
// From acceptance to frame_valid a triangle passes 8 setup stages,
// 16 square root stages (two result bits each), 8 divide stages (two
// quotient bits each) and 6 cross product and output stages.
// Throughput is one triangle per cycle unless a finished frame is held:
// a frame_stall on it freezes the whole pipeline and raises tri_stall.
// Reset clears all valid bits and loads the threshold with 1074.
module triangle_tangent_frame_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tri_valid,
    output logic                       tri_stall,
    input  ttf_pkg::ttf_in_t           tri_data,
    output logic                       frame_valid,
    input  logic                       frame_stall,
    output ttf_pkg::ttf_out_t          frame_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ttf_pkg::THR_W-1:0]  cfg_data
);
    import ttf_pkg::*;

    logic [THR_W-1:0]   thr_reg;
    logic               adv;

    logic               fr_valid;
    logic [SW-1:0]      fr_sum;
    ttf_mag3_t          fr_mag;
    ttf_ctx_t           fr_ctx;

    logic               sq_valid;
    logic [LW-1:0]      sq_len;
    ttf_mag3_t          sq_mag;
    ttf_ctx_t           sq_ctx;

    logic               dv_valid;
    logic [2:0][QW-1:0] dv_quo;
    ttf_ctx_t           dv_ctx;

    // The pipeline moves unless a finished frame is held.
    assign adv = !frame_valid || !frame_stall;
    assign tri_stall = !adv;
    assign cfg_ready = 1'b1;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    ttf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .req_valid (tri_valid),
        .req       (tri_data),
        .threshold (thr_reg),
        .res_valid (fr_valid),
        .res_sum   (fr_sum),
        .res_mag   (fr_mag),
        .res_ctx   (fr_ctx)
    );

    ttf_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .req_valid (fr_valid),
        .req_sum   (fr_sum),
        .req_mag   (fr_mag),
        .req_ctx   (fr_ctx),
        .res_valid (sq_valid),
        .res_len   (sq_len),
        .res_mag   (sq_mag),
        .res_ctx   (sq_ctx)
    );

    ttf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .req_valid (sq_valid),
        .req_len   (sq_len),
        .req_mag   (sq_mag),
        .req_ctx   (sq_ctx),
        .res_valid (dv_valid),
        .res_quo   (dv_quo),
        .res_ctx   (dv_ctx)
    );

    ttf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .req_valid (dv_valid),
        .req_quo   (dv_quo),
        .req_ctx   (dv_ctx),
        .res_valid (frame_valid),
        .res       (frame_data)
    );

endmodule

// ===== verif/triangle_tangent_frame_unit_tb.sv =====
`timescale 1ns / 1ps

module triangle_tangent_frame_unit_tb;

    import ttf_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int ITEMS_PER_PHASE = 67;

    // Predicts tangent frames for accepted triangles and checks returned frames.
    class frame_scoreboard;
        logic [THR_W-1:0] threshold;
        ttf_out_t pending_frames[$];
        int mismatches;
        int frames_checked;
        int degenerate_seen;

        function new();
            threshold = THR_RESET;
            mismatches = 0;
            frames_checked = 0;
            degenerate_seen = 0;
        endfunction

        static function longint comp(logic [3*CW-1:0] v, int i);
            return longint'($signed(v[CW*i +: CW]));
        endfunction

        static function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        static function longint clamp16(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        static function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // Q.28 cross product term rounded half away from zero to Q1.14.
        static function longint round_cross(longint v);
            longint q;
            q = longint'((magnitude(v) + 64'd8192) >> 14);
            return clamp16(v < 0 ? -q : q);
        endfunction

        function ttf_out_t predict_frame(ttf_in_t tri_in);
            longint pa[3], pb[3], pc[3], nrm[3], e1[3], e2[3];
            longint tang[3], bref[3], unit_t[3], bit_t[3];
            longint unsigned m[3], mx, sum, len;
            longint du1, dv1, du2, dv2, det, dot_ref;
            logic degen;
            ttf_out_t res;
            for (int i = 0; i < 3; i++)
            begin
                pa[i] = comp(tri_in.pos_a, i);
                pb[i] = comp(tri_in.pos_b, i);
                pc[i] = comp(tri_in.pos_c, i);
                nrm[i] = comp(tri_in.surface_normal, i);
                e1[i] = pb[i] - pa[i];
                e2[i] = pc[i] - pa[i];
            end
            du1 = comp(tri_in.tex_b, 0) - comp(tri_in.tex_a, 0);
            dv1 = comp(tri_in.tex_b, 1) - comp(tri_in.tex_a, 1);
            du2 = comp(tri_in.tex_c, 0) - comp(tri_in.tex_a, 0);
            dv2 = comp(tri_in.tex_c, 1) - comp(tri_in.tex_a, 1);
            det = du1 * dv2 - dv1 * du2;
            degen = (magnitude(det) * 64) < longint'(threshold);

            if (degen)
            begin
                unit_t[0] = 16384; unit_t[1] = 0; unit_t[2] = 0;
                bref[0] = 0; bref[1] = 0; bref[2] = 1;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    tang[i] = e1[i] * dv2 - e2[i] * dv1;
                    bref[i] = e2[i] * du1 - e1[i] * du2;
                    if (det < 0)
                    begin
                        tang[i] = -tang[i];
                        bref[i] = -bref[i];
                    end
                end
                // Scale magnitudes so the largest lies in [2^29, 2^30), then divide.
                mx = 0;
                for (int i = 0; i < 3; i++)
                begin
                    m[i] = magnitude(tang[i]);
                    if (m[i] > mx)
                        mx = m[i];
                end
                if (mx == 0)
                begin
                    unit_t[0] = 0; unit_t[1] = 0; unit_t[2] = 0;
                end
                else
                begin
                    while (mx >= (64'd1 << 30))
                    begin
                        mx = mx >> 1;
                        for (int i = 0; i < 3; i++)
                            m[i] = m[i] >> 1;
                    end
                    while (mx < (64'd1 << 29))
                    begin
                        mx = mx << 1;
                        for (int i = 0; i < 3; i++)
                            m[i] = m[i] << 1;
                    end
                    sum = 0;
                    for (int i = 0; i < 3; i++)
                        sum += m[i] * m[i];
                    len = int_sqrt(sum);
                    for (int i = 0; i < 3; i++)
                    begin
                        unit_t[i] = longint'((m[i] * 16384 + len / 2) / len);
                        if (tang[i] < 0)
                            unit_t[i] = -unit_t[i];
                    end
                end
            end

            bit_t[0] = round_cross(nrm[1] * unit_t[2] - nrm[2] * unit_t[1]);
            bit_t[1] = round_cross(nrm[2] * unit_t[0] - nrm[0] * unit_t[2]);
            bit_t[2] = round_cross(nrm[0] * unit_t[1] - nrm[1] * unit_t[0]);
            dot_ref = bit_t[0] * bref[0] + bit_t[1] * bref[1] + bit_t[2] * bref[2];
            if (dot_ref < 0)
                for (int i = 0; i < 3; i++)
                    bit_t[i] = clamp16(-bit_t[i]);

            for (int i = 0; i < 3; i++)
            begin
                res.tangent_out[CW*i +: CW] = unit_t[i][CW-1:0];
                res.bitangent_out[CW*i +: CW] = bit_t[i][CW-1:0];
            end
            res.degenerate = degen;
            return res;
        endfunction

        function void note_triangle(ttf_in_t tri_in);
            pending_frames.push_back(predict_frame(tri_in));
        endfunction

        function void check_frame(ttf_out_t got);
            ttf_out_t exp_frame;
            bit bad;
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected frame %h", got);
                return;
            end
            exp_frame = pending_frames.pop_front();
            frames_checked++;
            if (exp_frame.degenerate)
                degenerate_seen++;
            bad = (got.tangent_out !== exp_frame.tangent_out) ||
                  (got.bitangent_out !== exp_frame.bitangent_out) ||
                  (got.degenerate !== exp_frame.degenerate);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: frame %0d: tangent %h/%h bitangent %h/%h degen %b/%b",
                             frames_checked, exp_frame.tangent_out, got.tangent_out,
                             exp_frame.bitangent_out, got.bitangent_out,
                             exp_frame.degenerate, got.degenerate);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic tri_valid;
    logic tri_stall;
    ttf_in_t tri_data;
    logic frame_valid;
    logic frame_stall = 1'b0;
    ttf_out_t frame_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [THR_W-1:0] cfg_data;

    frame_scoreboard frames_sb;
    int send_idle_pct;
    int stall_pct;
    int idle_cycles = 0;
    int triangles_sent;

    triangle_tangent_frame_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .tri_valid   (tri_valid),
        .tri_stall   (tri_stall),
        .tri_data    (tri_data),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_data  (frame_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // Clock generation.
    always #4 clk = ~clk;

    // Frame receiver: check accepted frames and stall at random.
    always @(posedge clk)
    begin
        if (rst_n && frame_valid && !frame_stall)
            frames_sb.check_frame(frame_data);
        frame_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog on cycles in which nothing is accepted.
    always @(posedge clk)
    begin
        if ((tri_valid && !tri_stall) || (frame_valid && !frame_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [3*CW-1:0] vec3(int x, int y, int z);
        logic [CW-1:0] a, b, c;
        a = x[CW-1:0];
        b = y[CW-1:0];
        c = z[CW-1:0];
        return {c, b, a};
    endfunction

    function automatic logic [2*CW-1:0] uv(int u, int v);
        logic [CW-1:0] a, b;
        a = u[CW-1:0];
        b = v[CW-1:0];
        return {b, a};
    endfunction

    function automatic int srand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic ttf_in_t random_triangle();
        ttf_in_t t;
        int kind;
        int bx, by, bz, su, sv;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            // Raw bit patterns over every field.
            t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
        end
        else
        begin
            bx = srand(30000); by = srand(30000); bz = srand(30000);
            t.pos_a = vec3(bx, by, bz);
            t.pos_b = vec3(bx + srand(2000), by + srand(2000), bz + srand(2000));
            t.pos_c = vec3(bx + srand(2000), by + srand(2000), bz + srand(2000));
            su = srand(30000); sv = srand(30000);
            t.tex_a = uv(su, sv);
            if (kind == 1)
            begin
                // Near-collinear texture coordinates give a tiny determinant.
                t.tex_b = uv(su + 40, sv + 40);
                t.tex_c = uv(su + 80 + srand(1), sv + 80 + srand(1));
            end
            else
            begin
                t.tex_b = uv(su + srand(4096), sv + srand(4096));
                t.tex_c = uv(su + srand(4096), sv + srand(4096));
            end
            t.surface_normal = vec3(srand(16384), srand(16384), srand(16384));
        end
        return t;
    endfunction

    // Valid stays high after an accepted request until the next request or an idle cycle.
    task automatic send_triangle(ttf_in_t t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tri_valid <= 1'b0;
            @(posedge clk);
        end
        tri_valid <= 1'b1;
        tri_data <= t;
        forever
        begin
            @(posedge clk);
            if (!tri_stall)
                break;
        end
        frames_sb.note_triangle(t);
        triangles_sent++;
    endtask

    // Let the unit drain, then hold off for the pipeline depth.
    task automatic wait_drained();
        tri_valid <= 1'b0;
        while (frames_sb.pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        cfg_valid <= 1'b0;
        frames_sb.threshold = value;
    endtask

    task automatic send_directed();
        ttf_in_t t;
        // Well-formed triangle in the xy plane with a z normal.
        t.pos_a = vec3(0, 0, 0);
        t.pos_b = vec3(256, 0, 0);
        t.pos_c = vec3(0, 256, 0);
        t.tex_a = uv(0, 0);
        t.tex_b = uv(4096, 0);
        t.tex_c = uv(0, 4096);
        t.surface_normal = vec3(0, 0, 16384);
        send_triangle(t);
        // Mirrored texture gives a negative determinant.
        t.tex_b = uv(-4096, 0);
        send_triangle(t);
        // Equal texture coordinates: zero determinant.
        t.tex_b = uv(0, 0);
        t.tex_c = uv(0, 0);
        send_triangle(t);
        // Positions all equal with a good determinant: zero tangent.
        t.pos_b = vec3(0, 0, 0);
        t.pos_c = vec3(0, 0, 0);
        t.tex_b = uv(4096, 0);
        t.tex_c = uv(0, 4096);
        send_triangle(t);
        // Zero normal: bitangent zero and the dot product exactly zero.
        t.pos_b = vec3(256, 0, 0);
        t.pos_c = vec3(0, 256, 0);
        t.surface_normal = vec3(0, 0, 0);
        send_triangle(t);
        // Oversized normal drives the cross product into saturation.
        t.surface_normal = vec3(-32768, -32768, 32767);
        send_triangle(t);
        t.surface_normal = vec3(32767, 32767, -32768);
        send_triangle(t);
        // Extreme positions and texture coordinates.
        t.pos_a = vec3(-32768, -32768, -32768);
        t.pos_b = vec3(32767, 32767, 32767);
        t.pos_c = vec3(32767, -32768, 32767);
        t.tex_a = uv(-32768, -32768);
        t.tex_b = uv(32767, -32768);
        t.tex_c = uv(-32768, 32767);
        t.surface_normal = vec3(16384, 0, 0);
        send_triangle(t);
        t.tex_b = uv(-32768, 32767);
        t.tex_c = uv(32767, -32768);
        send_triangle(t);
        // Determinant just around the reset threshold (|det|*64 vs 1074).
        t.pos_a = vec3(0, 0, 0);
        t.pos_b = vec3(100, 3, 0);
        t.pos_c = vec3(5, 90, 7);
        t.tex_a = uv(0, 0);
        t.tex_b = uv(4, 0);
        t.tex_c = uv(0, 4);
        send_triangle(t);
        t.tex_c = uv(0, 5);
        send_triangle(t);
        // Tangent along a single axis with a negative component.
        t.pos_b = vec3(0, 0, -512);
        t.tex_b = uv(4096, 0);
        t.tex_c = uv(0, 4096);
        t.surface_normal = vec3(0, 16384, 0);
        send_triangle(t);
        // All ones and all zeros.
        t = '1;
        send_triangle(t);
        t = '0;
        send_triangle(t);
    endtask

    initial
    begin
        logic [THR_W-1:0] thr_list[5];
        int degen_total;
        clk = 1'b0;
        rst_n = 1'b0;
        tri_valid = 1'b0;
        tri_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        triangles_sent = 0;
        frames_sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        thr_list[0] = THR_RESET;
        thr_list[1] = '0;
        thr_list[2] = '1;
        thr_list[3] = THR_W'($urandom_range(0, 1 << 26));
        thr_list[4] = 31'd1 << 24;
        for (int p = 0; p < 5; p++)
        begin
            write_threshold(thr_list[p]);
            for (int mode = 0; mode < 4; mode++)
            begin
                case (mode)
                    0: begin send_idle_pct = 0;  stall_pct = 0;  end
                    1: begin send_idle_pct = 84; stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  stall_pct = 84; end
                    default: begin send_idle_pct = 36; stall_pct = 36; end
                endcase
                for (int k = 0; k < ITEMS_PER_PHASE; k++)
                    send_triangle(random_triangle());
                // Once per threshold the sender waits for every frame.
                if (mode == 1)
                    wait_drained();
            end
        end

        wait_drained();
        degen_total = frames_sb.degenerate_seen;
        $display("Run covered %0d triangles over %0d thresholds and 4 idle mixes;",
                 triangles_sent, 5);
        $display("%0d frames checked, %0d used the fallback frame, %0d mismatches.",
                 frames_sb.frames_checked, degen_total, frames_sb.mismatches);
        if (frames_sb.mismatches == 0 && frames_sb.pending_frames.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
